// ----- rtl/sdf_pkg.sv -----
// Shared types and constants for the spectral delay with feedback.
// No dependencies; every other file takes its names from here by scope or by import.
`timescale 1ns / 1ps
`default_nettype none

package sdf_pkg;

	localparam int DATA_W     = 24;
	localparam int GAIN_W     = 16;
	localparam int PROD_W     = DATA_W + GAIN_W;
	localparam int WORD_W     = 2 * DATA_W;
	localparam int DELAY_W    = 6;
	localparam int NBINS_W    = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int MAX_DELAY_FRAMES_DEF = 64;
	localparam int MAX_BINS_DEF         = 513;

	localparam logic [GAIN_W-1:0]  FB_LIMIT     = 16'd64880;
	localparam logic [NBINS_W-1:0] NUM_BINS_RST = 10'd513;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRAMES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_ENABLE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS      = 3'd4;

	typedef struct packed {
		logic [GAIN_W-1:0] delay_gain;
		logic [GAIN_W-1:0] fb_gain;
		logic              freq_en;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/sdf_cfg.sv -----
// Configuration register file with clamped working values.
// Depends on sdf_pkg for register indexes, widths and the gain struct.
`timescale 1ns / 1ps
`default_nettype none

module sdf_cfg #(
	parameter int MAX_DELAY_FRAMES = sdf_pkg::MAX_DELAY_FRAMES_DEF,
	parameter int MAX_BINS         = sdf_pkg::MAX_BINS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sdf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sdf_pkg::CFG_DATA_W-1:0]    cfg_data,
	output sdf_pkg::cfg_t                          cfg,
	output logic [$clog2(MAX_DELAY_FRAMES)-1:0]    delay_d,
	output logic [$clog2(MAX_BINS)-1:0]            last_bin
);

	localparam int FW = $clog2(MAX_DELAY_FRAMES);
	localparam int BW = $clog2(MAX_BINS);

	logic [sdf_pkg::DELAY_W-1:0] delay_frames_q;
	logic [sdf_pkg::GAIN_W-1:0]  delay_gain_q;
	logic [sdf_pkg::GAIN_W-1:0]  fb_gain_q;
	logic                        freq_en_q;
	logic [sdf_pkg::NBINS_W-1:0] num_bins_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_frames_q <= '0;
			delay_gain_q   <= '0;
			fb_gain_q      <= '0;
			freq_en_q      <= 1'b0;
			num_bins_q     <= sdf_pkg::NUM_BINS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sdf_pkg::REG_DELAY_FRAMES:  delay_frames_q <= cfg_data[sdf_pkg::DELAY_W-1:0];
				sdf_pkg::REG_DELAY_GAIN:    delay_gain_q   <= cfg_data[sdf_pkg::GAIN_W-1:0];
				sdf_pkg::REG_FEEDBACK_GAIN: fb_gain_q      <= cfg_data[sdf_pkg::GAIN_W-1:0];
				sdf_pkg::REG_FREQ_ENABLE:   freq_en_q      <= cfg_data[0];
				sdf_pkg::REG_NUM_BINS:      num_bins_q     <= cfg_data[sdf_pkg::NBINS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.delay_gain = delay_gain_q;
		cfg.fb_gain    = (fb_gain_q > sdf_pkg::FB_LIMIT) ? sdf_pkg::FB_LIMIT : fb_gain_q;
		cfg.freq_en    = freq_en_q;
	end

	always_comb begin
		if (32'(delay_frames_q) > 32'(MAX_DELAY_FRAMES - 1)) begin
			delay_d = FW'(MAX_DELAY_FRAMES - 1);
		end else begin
			delay_d = FW'(delay_frames_q);
		end
	end

	always_comb begin
		if (num_bins_q == '0) begin
			last_bin = '0;
		end else if (32'(num_bins_q) > 32'(MAX_BINS)) begin
			last_bin = BW'(MAX_BINS - 1);
		end else begin
			last_bin = BW'(num_bins_q - 10'd1);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sdf_store.sv -----
// Frame delay memory: one write port, one registered read port, zeroing sweep after reset.
// Depends on sdf_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module sdf_store #(
	parameter int MAX_DELAY_FRAMES = sdf_pkg::MAX_DELAY_FRAMES_DEF,
	parameter int MAX_BINS         = sdf_pkg::MAX_BINS_DEF
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        rd_en,
	input  wire logic [$clog2(MAX_DELAY_FRAMES*MAX_BINS)-1:0] rd_addr,
	output logic [sdf_pkg::WORD_W-1:0]                       rd_data,
	input  wire logic                                        wr_en,
	input  wire logic [$clog2(MAX_DELAY_FRAMES*MAX_BINS)-1:0] wr_addr,
	input  wire logic [sdf_pkg::WORD_W-1:0]                  wr_data,
	output logic                                             clearing
);

	localparam int DEPTH = MAX_DELAY_FRAMES * MAX_BINS;
	localparam int AW    = $clog2(DEPTH);

	logic [sdf_pkg::WORD_W-1:0] mem [DEPTH];
	logic [sdf_pkg::WORD_W-1:0] rd_data_q;
	logic [AW-1:0]              clr_q;
	logic                       clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clr_busy_q;

endmodule

`default_nettype wire

// ----- rtl/sdf_mac.sv -----
// Gain multipliers and saturating adders for the output and feedback paths.
// Depends on sdf_pkg for widths and the gain struct.
`timescale 1ns / 1ps
`default_nettype none

module sdf_mac (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [sdf_pkg::WORD_W-1:0]    rd_data,
	input  wire logic [sdf_pkg::DATA_W-1:0]    amp_s1,
	input  wire logic [sdf_pkg::DATA_W-1:0]    freq_s1,
	input  wire sdf_pkg::cfg_t                 cfg,
	output logic [sdf_pkg::DATA_W-1:0]         amp_res,
	output logic [sdf_pkg::DATA_W-1:0]         freq_res,
	output logic [sdf_pkg::DATA_W-1:0]         amp_st,
	output logic [sdf_pkg::DATA_W-1:0]         freq_st
);

	localparam int DW = sdf_pkg::DATA_W;
	localparam int PW = sdf_pkg::PROD_W;
	localparam int SW = DW + 2;

	logic [DW-1:0] damp;
	logic [DW-1:0] dfreq;
	logic [PW-1:0] amp_dg_s2;
	logic [PW-1:0] freq_dg_s2;
	logic [PW-1:0] amp_fb_s2;
	logic [PW-1:0] freq_fb_s2;
	logic [DW-1:0] amp_s2;
	logic [DW-1:0] freq_s2;

	function automatic logic [DW-1:0] sat(input logic [SW-1:0] v);
		logic [DW-1:0] r;
		r = (v > SW'({DW{1'b1}})) ? {DW{1'b1}} : v[DW-1:0];
		return r;
	endfunction

	assign damp  = rd_data[sdf_pkg::WORD_W-1:DW];
	assign dfreq = rd_data[DW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			amp_dg_s2  <= PW'(damp) * PW'(cfg.delay_gain);
			freq_dg_s2 <= PW'(dfreq) * PW'(cfg.delay_gain);
			amp_fb_s2  <= PW'(damp) * PW'(cfg.fb_gain);
			freq_fb_s2 <= PW'(dfreq) * PW'(cfg.fb_gain);
			amp_s2     <= amp_s1;
			freq_s2    <= freq_s1;
		end
	end

	always_comb begin
		amp_res = sat(SW'(amp_s2) + SW'(amp_dg_s2[PW-1:15]));
		if (cfg.freq_en) begin
			freq_res = sat(SW'(freq_s2) + SW'(freq_dg_s2[PW-1:15]));
		end else begin
			freq_res = freq_s2;
		end
		amp_st  = sat(SW'(amp_s2) + SW'(amp_fb_s2[PW-1:16]));
		freq_st = sat(SW'(freq_s2) + SW'(freq_fb_s2[PW-1:16]));
	end

endmodule

`default_nettype wire

// ----- rtl/spectral_delay_feedback.sv -----
// Spectral delay with feedback: bin sequencer, read-after-write interlock and output register.
// Depends on sdf_pkg, sdf_cfg, sdf_store and sdf_mac.
//
// Usage:
//   Bins arrive on in_valid/in_stall, one transaction per bin, frame after frame of
//   num_bins bins. Each result leaves on out_valid/out_stall; frame_end marks the last
//   bin of a frame. Registers are written on cfg_valid/cfg_ready (always ready); the user
//   must write them only while the block is idle, the block itself does not enforce it.
//   Path: an accepted bin passes the read, product and output registers in that order.
//   Throughput: one bin per cycle while nothing stalls, set by the single read and single
//   write port of the delay memory. When the bin being read is still in flight (num_bins
//   times the delay at most two) the input stalls until that write lands.
//   Reset: the delay memory is zeroed one entry per cycle, over all MAX_DELAY_FRAMES *
//   MAX_BINS entries (32832 by default); in_stall stays high meanwhile, configuration
//   writes are taken throughout. Frame and bin counters return to zero.
//   Stall: while out_stall holds a waiting result the pipeline freezes and in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module spectral_delay_feedback #(
	parameter int MAX_DELAY_FRAMES = sdf_pkg::MAX_DELAY_FRAMES_DEF,
	parameter int MAX_BINS         = sdf_pkg::MAX_BINS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [sdf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sdf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [sdf_pkg::DATA_W-1:0]     amp_in,
	input  wire logic [sdf_pkg::DATA_W-1:0]     freq_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [sdf_pkg::DATA_W-1:0]          amp_out,
	output logic [sdf_pkg::DATA_W-1:0]          freq_out,
	output logic                                frame_end
);

	localparam int FW    = $clog2(MAX_DELAY_FRAMES);
	localparam int BW    = $clog2(MAX_BINS);
	localparam int DEPTH = MAX_DELAY_FRAMES * MAX_BINS;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = sdf_pkg::DATA_W;

	sdf_pkg::cfg_t cfg;
	logic [FW-1:0] delay_d;
	logic [BW-1:0] last_bin;

	logic [FW-1:0] wf_q;
	logic [BW-1:0] bin_q;
	logic [FW-1:0] rd_frame;
	logic [BW-1:0] bin_cur;
	logic          is_last;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	logic clearing;
	logic adv;
	logic hazard;
	logic accept;

	logic          s1_valid;
	logic          last_s1;
	logic [AW-1:0] wr_addr_s1;
	logic [DW-1:0] amp_s1;
	logic [DW-1:0] freq_s1;
	logic          s2_valid;
	logic          last_s2;
	logic [AW-1:0] wr_addr_s2;

	logic [sdf_pkg::WORD_W-1:0] rd_data;
	logic [DW-1:0] amp_res;
	logic [DW-1:0] freq_res;
	logic [DW-1:0] amp_st;
	logic [DW-1:0] freq_st;

	logic          out_valid_q;
	logic [DW-1:0] amp_out_q;
	logic [DW-1:0] freq_out_q;
	logic          frame_end_q;

	sdf_cfg #(
		.MAX_DELAY_FRAMES(MAX_DELAY_FRAMES),
		.MAX_BINS        (MAX_BINS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg),
		.delay_d  (delay_d),
		.last_bin (last_bin)
	);

	always_comb begin
		is_last = (bin_q >= last_bin);
		bin_cur = is_last ? last_bin : bin_q;
		if (wf_q >= delay_d) begin
			rd_frame = wf_q - delay_d;
		end else begin
			rd_frame = FW'({1'b0, wf_q} + (FW+1)'(MAX_DELAY_FRAMES) - {1'b0, delay_d});
		end
		rd_addr = AW'(32'(rd_frame) * 32'(MAX_BINS) + 32'(bin_cur));
		wr_addr = AW'(32'(wf_q) * 32'(MAX_BINS) + 32'(bin_cur));
	end

	assign hazard   = (s1_valid && (rd_addr == wr_addr_s1)) ||
	                  (s2_valid && (rd_addr == wr_addr_s2));
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = clearing || !adv || hazard;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wf_q        <= '0;
			bin_q       <= '0;
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (is_last) begin
					bin_q <= '0;
					if (wf_q == FW'(MAX_DELAY_FRAMES - 1)) begin
						wf_q <= '0;
					end else begin
						wf_q <= wf_q + 1'b1;
					end
				end else begin
					bin_q <= bin_cur + 1'b1;
				end
			end
			if (adv) begin
				s1_valid    <= accept;
				s2_valid    <= s1_valid;
				out_valid_q <= s2_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amp_s1     <= amp_in;
			freq_s1    <= freq_in;
			last_s1    <= is_last;
			wr_addr_s1 <= wr_addr;
		end
		if (adv) begin
			last_s2    <= last_s1;
			wr_addr_s2 <= wr_addr_s1;
		end
		if (adv && s2_valid) begin
			amp_out_q   <= amp_res;
			freq_out_q  <= freq_res;
			frame_end_q <= last_s2;
		end
	end

	sdf_store #(
		.MAX_DELAY_FRAMES(MAX_DELAY_FRAMES),
		.MAX_BINS        (MAX_BINS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (adv && s2_valid),
		.wr_addr (wr_addr_s2),
		.wr_data ({amp_st, freq_st}),
		.clearing(clearing)
	);

	sdf_mac u_mac (
		.clk     (clk),
		.en      (adv),
		.rd_data (rd_data),
		.amp_s1  (amp_s1),
		.freq_s1 (freq_s1),
		.cfg     (cfg),
		.amp_res (amp_res),
		.freq_res(freq_res),
		.amp_st  (amp_st),
		.freq_st (freq_st)
	);

	assign out_valid = out_valid_q;
	assign amp_out   = amp_out_q;
	assign freq_out  = freq_out_q;
	assign frame_end = frame_end_q;

`ifndef ASSERT_OFF
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !accept)
		else $error("bin accepted during memory clear");

	a_no_read_overtake: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !(s1_valid && (rd_addr == wr_addr_s1)) &&
		           !(s2_valid && (rd_addr == wr_addr_s2)))
		else $error("read issued ahead of a pending write to the same entry");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		wf_q <= FW'(MAX_DELAY_FRAMES - 1))
		else $error("write frame out of range");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		bin_q <= BW'(MAX_BINS - 1))
		else $error("bin position out of range");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/sdf_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the spectral delay with feedback: follows register writes, keeps its own
// copy of the frame delay store and checks every accepted bin result against its prediction.
// Depends on sdf_pkg; instantiated beside the block by tb_spectral_delay_feedback.

module sdf_checker #(
	parameter int MAX_DELAY_FRAMES = sdf_pkg::MAX_DELAY_FRAMES_DEF,
	parameter int MAX_BINS         = sdf_pkg::MAX_BINS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [sdf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sdf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [sdf_pkg::DATA_W-1:0]     amp_in,
	input  logic [sdf_pkg::DATA_W-1:0]     freq_in,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [sdf_pkg::DATA_W-1:0]     amp_out,
	input  logic [sdf_pkg::DATA_W-1:0]     freq_out,
	input  logic                           frame_end,
	output int                             n_errors,
	output int                             n_pending
);

	import sdf_pkg::*;

	localparam int DEPTH = MAX_DELAY_FRAMES * MAX_BINS;

	typedef struct packed {
		logic [DATA_W-1:0] amp;
		logic [DATA_W-1:0] freq;
		logic              last;
	} bin_result_t;

	logic [DELAY_W-1:0] delay_frames;
	logic [GAIN_W-1:0]  delay_gain;
	logic [GAIN_W-1:0]  fb_gain;
	logic               freq_en;
	logic [NBINS_W-1:0] num_bins;

	logic [DATA_W-1:0] echo_amp  [0:DEPTH-1];
	logic [DATA_W-1:0] echo_freq [0:DEPTH-1];
	int                wr_frame;
	int                bin_pos;
	bin_result_t       mix_q [$];
	int                fails;

	function automatic logic [DATA_W-1:0] clip(input logic [PROD_W:0] v);
		return (|v[PROD_W:DATA_W]) ? {DATA_W{1'b1}} : v[DATA_W-1:0];
	endfunction

	// delayed value times gain, shifted down to the data scale, plus the fresh value
	function automatic logic [PROD_W:0] gained(input logic [DATA_W-1:0] x,
			input logic [GAIN_W-1:0] g, input int sh, input logic [DATA_W-1:0] add);
		logic [PROD_W-1:0] p;
		p = PROD_W'(x) * PROD_W'(g);
		return (PROD_W + 1)'(p >> sh) + (PROD_W + 1)'(add);
	endfunction

	task automatic mix_bin(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] f);
		int                n, d, bin, rd, wr;
		logic [GAIN_W-1:0] fb;
		logic              last;
		logic [DATA_W-1:0] da, df;
		bin_result_t       r;
		n = (num_bins == 0) ? 1 : (num_bins > MAX_BINS) ? MAX_BINS : int'(num_bins);
		d = (delay_frames > MAX_DELAY_FRAMES - 1) ? MAX_DELAY_FRAMES - 1 : int'(delay_frames);
		fb = (fb_gain > FB_LIMIT) ? FB_LIMIT : fb_gain;
		// a bin count lowered under the running position closes the frame on its last bin
		last = (bin_pos >= n - 1);
		bin = last ? n - 1 : bin_pos;
		rd = ((wr_frame + MAX_DELAY_FRAMES - d) % MAX_DELAY_FRAMES) * MAX_BINS + bin;
		wr = wr_frame * MAX_BINS + bin;
		da = echo_amp[rd];
		df = echo_freq[rd];
		r.amp = clip(gained(da, delay_gain, 15, a));
		r.freq = freq_en ? clip(gained(df, delay_gain, 15, f)) : f;
		r.last = last;
		mix_q.push_back(r);
		echo_amp[wr] = clip(gained(da, fb, 16, a));
		echo_freq[wr] = clip(gained(df, fb, 16, f));
		if (last) begin
			bin_pos = 0;
			wr_frame = (wr_frame + 1) % MAX_DELAY_FRAMES;
		end else begin
			bin_pos = bin + 1;
		end
	endtask

	task automatic report(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		fails++;
		$display("%0t: %s expected %h, got %h", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		bin_result_t want;
		if (!arst_n) begin
			delay_frames = '0;
			delay_gain = '0;
			fb_gain = '0;
			freq_en = 1'b0;
			num_bins = NUM_BINS_RST;
			for (int i = 0; i < DEPTH; i++) begin
				echo_amp[i] = '0;
				echo_freq[i] = '0;
			end
			wr_frame = 0;
			bin_pos = 0;
			mix_q.delete();
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DELAY_FRAMES: delay_frames = cfg_data[DELAY_W-1:0];
					REG_DELAY_GAIN: delay_gain = cfg_data[GAIN_W-1:0];
					REG_FEEDBACK_GAIN: fb_gain = cfg_data[GAIN_W-1:0];
					REG_FREQ_ENABLE: freq_en = cfg_data[0];
					REG_NUM_BINS: num_bins = cfg_data[NBINS_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (mix_q.size() == 0) begin
					report("unexpected transaction, amp_out", '0, amp_out);
				end else begin
					want = mix_q.pop_front();
					if (amp_out !== want.amp)
						report("amp_out", want.amp, amp_out);
					if (freq_out !== want.freq)
						report("freq_out", want.freq, freq_out);
					if (frame_end !== want.last)
						report("frame_end", DATA_W'(want.last), DATA_W'(frame_end));
				end
			end
			if (in_valid && !in_stall)
				mix_bin(amp_in, freq_in);
		end
		n_errors <= fails;
		n_pending <= mix_q.size();
	end

endmodule

// ----- tb/sv/tb_spectral_delay_feedback.sv -----
`timescale 1ns / 1ps
// Top of the spectral delay with feedback testbench: clock, reset, register writes, bin
// stimulus with bursts and gaps, a stalling receiver and the verdict.
// Depends on sdf_pkg, sdf_checker and the block under test.

module tb_spectral_delay_feedback;

	import sdf_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1600;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [DATA_W-1:0]     amp_in;
	logic [DATA_W-1:0]     freq_in;
	logic                  out_valid;
	logic                  out_stall;
	logic [DATA_W-1:0]     amp_out;
	logic [DATA_W-1:0]     freq_out;
	logic                  frame_end;
	int                    n_errors;
	int                    n_pending;
	int                    burst_left;

	spectral_delay_feedback u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.amp_in    (amp_in),
		.freq_in   (freq_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.amp_out   (amp_out),
		.freq_out  (freq_out),
		.frame_end (frame_end)
	);

	sdf_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.amp_in    (amp_in),
		.freq_in   (freq_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.amp_out   (amp_out),
		.freq_out  (freq_out),
		.frame_end (frame_end),
		.n_errors  (n_errors),
		.n_pending (n_pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [DATA_W-1:0] bin_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return DATA_W'($urandom_range(0, 255));
			3: return ~DATA_W'($urandom_range(0, 255));
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// unused upper bits of the write data carry random noise
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		logic [CFG_DATA_W-1:0] mask;
		case (idx)
			REG_DELAY_FRAMES: mask = CFG_DATA_W'((1 << DELAY_W) - 1);
			REG_DELAY_GAIN, REG_FEEDBACK_GAIN: mask = '1;
			REG_FREQ_ENABLE: mask = CFG_DATA_W'(1);
			REG_NUM_BINS: mask = CFG_DATA_W'((1 << NBINS_W) - 1);
			default: mask = '0;
		endcase
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(value) & mask);
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input int unsigned dly, input int unsigned gain,
			input int unsigned fbg, input int unsigned fen, input int unsigned nb,
			input bit stray);
		write_reg(REG_DELAY_FRAMES, dly);
		write_reg(REG_DELAY_GAIN, gain);
		write_reg(REG_FEEDBACK_GAIN, fbg);
		write_reg(REG_FREQ_ENABLE, fen);
		write_reg(REG_NUM_BINS, nb);
		if (stray) begin
			for (int i = REG_NUM_BINS + 1; i < (1 << CFG_IDX_W); i++)
				write_reg(CFG_IDX_W'(i), $urandom);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_bin(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] f);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		amp_in <= a;
		freq_in <= f;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_bin(bin_word(), bin_word());
	endtask

	// hold until every predicted result has been taken
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (n_pending != 0);
	endtask

	initial begin : downstream
		int   cyc, mode, hold, hold_at, seen;
		logic stall_nx;
		cyc = 0;
		mode = 0;
		hold = 0;
		hold_at = 150;
		seen = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				seen++;
			cyc++;
			if (cyc % 97 == 0)
				mode = $urandom_range(0, 3);
			if (hold == 0 && seen >= hold_at) begin
				hold = 300;
				hold_at += 900;
			end
			if (hold != 0) begin
				hold--;
				stall_nx = 1'b1;
			end else begin
				case (mode)
					0: stall_nx = 1'b0;
					1: stall_nx = ($urandom_range(0, 3) == 0);
					2: stall_nx = ($urandom_range(0, 3) != 0);
					default: stall_nx = (cyc % 7) < 3;
				endcase
			end
			out_stall <= stall_nx;
		end
	end

	initial begin : watchdog
		int cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("timeout after %0d cycles", cyc);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int nb, dly, gain, fbg, cnt, sent;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		amp_in = '0;
		freq_in = '0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// zero bin count, full gains with feedback clamp, stray register indexes
		configure(1, 16'hFFFF, 16'hFFFF, 1, 0, 1'b1);
		send_bin('1, '1);
		send_bin('0, '0);
		send_bin(24'h000001, 24'h800000);
		send_bin(24'h555555, 24'hAAAAAA);
		send_bin(24'hAAAAAA, 24'h555555);
		drain();

		// bin count above the frame size of the store, no delay, frequency path off
		configure(0, 16'h8000, 0, 0, (1 << NBINS_W) - 1, 1'b0);
		send_bin('1, '0);
		send_bin('0, '1);
		send_bin(24'h123456, 24'h654321);
		send_bin('1, '1);
		send_bin('0, '0);
		send_bin(24'h800000, 24'h7FFFFF);
		drain();

		// longest delay, then lower the bin count under the running position
		configure((1 << DELAY_W) - 1, 1, FB_LIMIT, 1, 8, 1'b0);
		send_random(3);
		drain();
		configure((1 << DELAY_W) - 1, 1, FB_LIMIT, 1, 2, 1'b0);
		send_random(3);
		drain();

		// feedback just over the clamp, wet gain off, full frame size
		configure(2, 0, FB_LIMIT + 1, 1, MAX_BINS_DEF, 1'b0);
		send_random(6);
		drain();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: nb = 0;
				1: nb = MAX_BINS_DEF;
				2: nb = $urandom_range(MAX_BINS_DEF + 1, (1 << NBINS_W) - 1);
				3: nb = $urandom_range(17, 200);
				default: nb = $urandom_range(1, 16);
			endcase
			case ($urandom_range(0, 7))
				0: dly = 0;
				1: dly = (1 << DELAY_W) - 1;
				2: dly = $urandom_range(1, 2);
				default: dly = $urandom_range(0, (1 << DELAY_W) - 1);
			endcase
			case ($urandom_range(0, 4))
				0: gain = 0;
				1: gain = 16'hFFFF;
				2: gain = 16'h8000;
				default: gain = $urandom_range(0, 16'hFFFF);
			endcase
			case ($urandom_range(0, 4))
				0: fbg = 0;
				1: fbg = FB_LIMIT;
				2: fbg = $urandom_range(FB_LIMIT + 1, 16'hFFFF);
				default: fbg = $urandom_range(0, 16'hFFFF);
			endcase
			configure(dly, gain, fbg, $urandom_range(0, 1), nb, $urandom_range(0, 7) == 0);
			cnt = $urandom_range(20, 120);
			send_random(cnt);
			drain();
			sent += cnt;
		end

		repeat (8) @(posedge clk);
		if (n_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
